// ===== design/perc_pkg.sv =====
package perc_pkg;

  // field and register widths
  localparam int OP_W      = 2;
  localparam int FEAT_W    = 16;
  localparam int IDX_W     = 4;
  localparam int WEIGHT_W  = 32;
  localparam int LR_W      = 16;
  localparam int BIAS_W    = 8;
  localparam int ACC_W     = 48;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // binary point of the accumulator (Q20.28)
  localparam int ACC_FRAC  = 28;

  // op codes
  localparam logic [OP_W-1:0] OP_PREDICT  = 2'd0;
  localparam logic [OP_W-1:0] OP_TRAIN    = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD     = 2'd2;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LRATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS  = 1'b1;

  localparam logic [LR_W-1:0]   LR_RESET   = 16'd655;
  localparam logic [BIAS_W-1:0] BIAS_RESET = 8'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_BIAS,
    ST_ALIGN,
    ST_UPDATE,
    ST_FINISH
  } perc_state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== design/perc_if.sv =====
interface perc_req_if;
  import perc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [FEAT_W-1:0]   feature;
  logic                       label;
  logic                       last;
  logic [IDX_W-1:0]           weight_index;
  logic signed [WEIGHT_W-1:0] weight_value;

  modport source (output valid, op, feature, label, last, weight_index, weight_value,
                  input ready);
  modport sink   (input valid, op, feature, label, last, weight_index, weight_value,
                  output ready);
endinterface

interface perc_rsp_if;
  import perc_pkg::*;

  logic valid;
  logic ready;
  logic prediction;
  logic updated;
  logic saturated;

  modport source (output valid, prediction, updated, saturated, input ready);
  modport sink   (input valid, prediction, updated, saturated, output ready);
endinterface

// ===== design/perc_cell.sv =====
module perc_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  perc_pkg::cell_ctl_t                  ctl,
  input  logic signed [perc_pkg::WEIGHT_W-1:0] weight_in,
  input  logic signed [perc_pkg::FEAT_W-1:0]   sample_in,
  input  logic signed [perc_pkg::WEIGHT_W-1:0] load_value,
  output logic signed [perc_pkg::WEIGHT_W-1:0] weight,
  output logic signed [perc_pkg::FEAT_W-1:0]   sample
);
  import perc_pkg::*;

  // load and shift never coincide
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (ctl.load) begin
      weight <= load_value;
    end else if (ctl.shift) begin
      weight <= weight_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sample <= sample_in;
    end
  end

endmodule

// ===== design/perceptron_train_predict.sv =====
// Online perceptron, predict and train. Weights (Q16.16) and the buffered features of the
// current sample (Q4.12) live in a ring of FEATURES cells that rotates toward cell 0; cell 0
// is the head that feeds the multiply-accumulate and the weight update unit. A feature word
// is multiplied as ST_IDLE takes it and added with 48-bit saturation in ST_ACC; it rotates
// the ring by one while it has room, so the head holds the weight for the next feature. A
// weight load (op 2) or a reserved op is taken in ST_IDLE, which stays ready. After the
// last word, ST_BIAS adds bias and takes the sign, ST_ALIGN turns the ring back to slot 0,
// then for a training sample with a wrong prediction ST_UPDATE walks the ring (one multiply
// on the single shared multiplier, one saturating add per cell) and ST_FINISH hands over
// the result. A new word is taken while a result still waits in the output register; only
// the final step of the next sample waits for it. lrate and bias are to be written
// on cfg_write by the user only while the block idles; the block does not enforce this.
module perceptron_train_predict #(
  parameter int FEATURES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [perc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [perc_pkg::CFG_W-1:0]            cfg_data,
  perc_req_if.sink                              req,
  perc_rsp_if.source                            rsp
);
  import perc_pkg::*;

  // rotation counter width, feature count width, width for load slot arithmetic
  localparam int RW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int PW = $clog2(FEATURES + 1);
  localparam int LW = ((RW > IDX_W) ? RW : IDX_W) + 1;
  // update path widths: lr*x, then +-2*lr*x with rounding headroom, then weight sum
  localparam int MW = LR_W + FEAT_W + 1;
  localparam int DW = MW + 2;
  localparam int NW = DW + 1;
  localparam int Q12 = 12;

  localparam logic [RW-1:0] ROT_LAST  = RW'(FEATURES - 1);
  localparam logic [PW-1:0] POS_FULL  = PW'(FEATURES);
  localparam logic [LW-1:0] SLOT_FULL = LW'(FEATURES);

  localparam logic signed [ACC_W:0]  ACC_HI  = (ACC_W + 1)'({1'b0, {(ACC_W - 1){1'b1}}});
  localparam logic signed [ACC_W:0]  ACC_LO  = (ACC_W + 1)'({2'b11, {(ACC_W - 1){1'b0}}});
  localparam logic signed [NW-1:0]   W_HI    = NW'({1'b0, {(WEIGHT_W - 1){1'b1}}});
  localparam logic signed [NW-1:0]   W_LO    = -(NW'({1'b1, {(WEIGHT_W - 1){1'b0}}}));
  localparam logic signed [DW-1:0]   RND_HALF = DW'(2048);

  // control state
  perc_state_t state, state_next;
  logic [PW-1:0] pos;          // features taken in this sample
  logic [RW-1:0] rot;          // logical slot now sitting in the head cell
  logic          phase;        // update walk: 0 multiply, 1 add and shift
  logic          sum_sat;      // sticky clamp of the running sum
  logic          out_valid;

  // configuration
  logic [LR_W-1:0]          lrate;
  logic signed [BIAS_W-1:0] bias;

  // datapath
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod;
  logic signed [MW-1:0]    upd_prod;
  logic                    last_word, train_word, label_word;
  logic                    pred, sat_flag, upd_flag, err;
  logic                    out_pred, out_upd, out_sat;

  // ring of cells
  logic signed [WEIGHT_W-1:0] cell_w [FEATURES];
  logic signed [FEAT_W-1:0]   cell_s [FEATURES];
  logic signed [WEIGHT_W-1:0] tail_w;
  logic signed [FEAT_W-1:0]   tail_s;
  logic                       shift_en, load_en, req_ready;
  logic [RW-1:0]              load_slot, rot_inc;

  // input word decode
  logic take, feat_word, load_word, pos_open, idx_ok;
  logic [LW-1:0] idx_ext, rot_ext, slot_l;

  assign take      = req.valid && req_ready;
  assign feat_word = (req.op == OP_PREDICT) || (req.op == OP_TRAIN);
  assign load_word = (req.op == OP_LOAD);
  assign pos_open  = pos < POS_FULL;

  // physical cell of a logical weight slot given the current rotation
  assign idx_ext = LW'(req.weight_index);
  assign rot_ext = LW'(rot);
  assign idx_ok  = idx_ext < SLOT_FULL;
  always_comb begin
    if (idx_ext >= rot_ext) begin
      slot_l = idx_ext - rot_ext;
    end else begin
      slot_l = idx_ext + SLOT_FULL - rot_ext;
    end
  end
  assign load_slot = slot_l[RW-1:0];

  assign rot_inc = (rot == ROT_LAST) ? '0 : rot + 1'b1;

  // saturating accumulate
  logic signed [ACC_W:0]   acc_sum, bias_sum, bias_ext;
  logic signed [ACC_W-1:0] acc_clamped, total;
  logic                    acc_clip, total_clip;

  assign acc_sum  = (ACC_W + 1)'(acc) + (ACC_W + 1)'(prod);
  assign bias_ext = (ACC_W + 1)'(bias) <<< ACC_FRAC;
  assign bias_sum = (ACC_W + 1)'(acc) + bias_ext;

  always_comb begin
    acc_clip = 1'b0;
    acc_clamped = acc_sum[ACC_W-1:0];
    if (acc_sum > ACC_HI) begin
      acc_clip = 1'b1;
      acc_clamped = ACC_HI[ACC_W-1:0];
    end else if (acc_sum < ACC_LO) begin
      acc_clip = 1'b1;
      acc_clamped = ACC_LO[ACC_W-1:0];
    end
  end

  always_comb begin
    total_clip = 1'b0;
    total = bias_sum[ACC_W-1:0];
    if (bias_sum > ACC_HI) begin
      total_clip = 1'b1;
      total = ACC_HI[ACC_W-1:0];
    end else if (bias_sum < ACC_LO) begin
      total_clip = 1'b1;
      total = ACC_LO[ACC_W-1:0];
    end
  end

  // weight update: delta = round(e*lr*x / 4096), e = +-2
  logic signed [DW-1:0]       step_v, delta;
  logic signed [NW-1:0]       w_sum;
  logic signed [WEIGHT_W-1:0] new_w;
  logic                       w_clip, in_sample;

  assign step_v    = label_word ? (DW'(upd_prod) <<< 1) : -(DW'(upd_prod) <<< 1);
  assign delta     = (step_v + RND_HALF) >>> Q12;
  assign w_sum     = NW'(cell_w[0]) + NW'(delta);
  assign in_sample = PW'(rot) < pos;

  always_comb begin
    w_clip = 1'b0;
    new_w = w_sum[WEIGHT_W-1:0];
    if (w_sum > W_HI) begin
      w_clip = 1'b1;
      new_w = W_HI[WEIGHT_W-1:0];
    end else if (w_sum < W_LO) begin
      w_clip = 1'b1;
      new_w = W_LO[WEIGHT_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && feat_word) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = last_word ? ST_BIAS : ST_IDLE;
      end
      ST_BIAS: begin
        state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (rot == '0) begin
          state_next = err ? ST_UPDATE : ST_FINISH;
        end
      end
      ST_UPDATE: begin
        if (phase && (rot == ROT_LAST)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ring control per state
  always_comb begin
    req_ready = 1'b0;
    shift_en  = 1'b0;
    load_en   = 1'b0;
    tail_w    = cell_w[0];
    tail_s    = cell_s[0];
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        shift_en  = take && feat_word && pos_open;
        load_en   = take && load_word && idx_ok;
        tail_s    = req.feature;
      end
      ST_ALIGN: begin
        shift_en = rot != '0;
      end
      ST_UPDATE: begin
        shift_en = phase;
        if (in_sample) begin
          tail_w = new_w;
        end
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  assign req.ready = req_ready;

  // the ring
  for (genvar k = 0; k < FEATURES; k++) begin : g_cell
    cell_ctl_t                  ctl;
    logic signed [WEIGHT_W-1:0] w_in;
    logic signed [FEAT_W-1:0]   s_in;

    if (k == FEATURES - 1) begin : g_tail
      assign w_in = tail_w;
      assign s_in = tail_s;
    end else begin : g_link
      assign w_in = cell_w[k+1];
      assign s_in = cell_s[k+1];
    end

    assign ctl.shift = shift_en;
    assign ctl.load  = load_en && (load_slot == RW'(k));

    perc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .weight_in  (w_in),
      .sample_in  (s_in),
      .load_value (req.weight_value),
      .weight     (cell_w[k]),
      .sample     (cell_s[k])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pos           <= '0;
      rot           <= '0;
      phase         <= 1'b0;
      sum_sat       <= 1'b0;
      acc           <= '0;
      out_valid     <= 1'b0;
      lrate         <= LR_RESET;
      bias          <= BIAS_RESET;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_LRATE: lrate <= cfg_data[LR_W-1:0];
          REG_BIAS:  bias  <= cfg_data[BIAS_W-1:0];
          default:   lrate <= lrate;
        endcase
      end

      if (shift_en) begin
        rot <= rot_inc;
      end

      if (state == ST_IDLE && take && feat_word && pos_open) begin
        pos <= pos + 1'b1;
      end

      if (state == ST_ACC) begin
        acc <= acc_clamped;
        if (acc_clip) begin
          sum_sat <= 1'b1;
        end
      end

      if (state == ST_UPDATE) begin
        phase <= !phase;
      end else begin
        phase <= 1'b0;
      end

      // result goes out, sample state starts over
      if (state == ST_FINISH && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
        acc       <= '0;
        pos       <= '0;
        sum_sat   <= 1'b0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take && feat_word) begin
      prod       <= pos_open ? ACC_W'(cell_w[0] * req.feature) : '0;
      last_word  <= req.last;
      train_word <= req.op == OP_TRAIN;
      label_word <= req.label;
    end

    if (state == ST_BIAS) begin
      pred     <= !total[ACC_W-1];
      sat_flag <= sum_sat || total_clip;
      upd_flag <= 1'b0;
      err      <= train_word && (label_word == total[ACC_W-1]);
    end

    if (state == ST_UPDATE && !phase) begin
      upd_prod <= $signed({1'b0, lrate}) * cell_s[0];
    end

    if (state == ST_UPDATE && phase && in_sample) begin
      if (new_w != cell_w[0]) begin
        upd_flag <= 1'b1;
      end
      if (w_clip) begin
        sat_flag <= 1'b1;
      end
    end

    if (state == ST_FINISH && (!out_valid || rsp.ready)) begin
      out_pred <= pred;
      out_upd  <= upd_flag;
      out_sat  <= sat_flag;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.prediction = out_pred;
  assign rsp.updated    = out_upd;
  assign rsp.saturated  = out_sat;

endmodule

// ===== design/perc_chk.sv =====
module perc_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [perc_pkg::OP_W-1:0]   req_op,
  input logic                        req_last,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_prediction,
  input logic                        rsp_updated,
  input logic                        rsp_saturated
);
  import perc_pkg::*;

  logic feat_take, other_take;

  assign feat_take  = req_valid && req_ready && ((req_op == OP_PREDICT) || (req_op == OP_TRAIN));
  assign other_take = req_valid && req_ready && ((req_op == OP_LOAD) || (req_op == OP_RESERVED));

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a waiting result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_prediction)
      && $stable(rsp_updated) && $stable(rsp_saturated)))
    else $error("result word dropped or changed while stalled");

  // weight load and reserved op leave the block ready in the next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    other_take |=> req_ready)
    else $error("block busy after a load word");

  // an inner feature word holds the block busy for its accumulate step, then it is ready again
  a_feature_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (feat_take && !req_last) |=> !req_ready ##1 req_ready)
    else $error("feature word timing off");

  // closing a sample takes at least accumulate, bias and align steps
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    (feat_take && req_last) |=> !req_ready ##1 !req_ready ##1 !req_ready)
    else $error("block ready too early after the last feature");

endmodule

bind perceptron_train_predict perc_chk u_perc_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_op         (req.op),
  .req_last       (req.last),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_prediction (rsp.prediction),
  .rsp_updated    (rsp.updated),
  .rsp_saturated  (rsp.saturated)
);

// ===== verif/perceptron_train_predict_tb.sv =====
`timescale 1ns / 1ps

module perceptron_train_predict_tb;
  import perc_pkg::*;

  localparam int FEATURES = 16;

  // cycles the block may still be busy after its last result
  // (bias and sign, ring turn, update walk, hand-over, with margin)
  localparam int DRAIN_CYCLES = 4 * FEATURES + 16;

  // saturation bounds of the 48-bit accumulator and of one weight
  localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint W_MAX   = 64'sd2147483647;
  localparam longint W_MIN   = -W_MAX - 1;

  // one request word and one response word
  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic signed [FEAT_W-1:0]   feature;
    logic                       label;
    logic                       last;
    logic [IDX_W-1:0]           widx;
    logic signed [WEIGHT_W-1:0] wval;
  } req_word_t;

  typedef struct packed {
    logic prediction;
    logic updated;
    logic saturated;
  } verdict_t;

  // opening row: a word, and a typed verdict where it is obvious
  typedef struct packed {
    req_word_t w;
    logic      typed;
    verdict_t  v;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  perc_req_if req_ch ();
  perc_rsp_if rsp_ch ();

  perceptron_train_predict #(
    .FEATURES (FEATURES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #4 clk = ~clk;

  // idle odds in percent, per cycle
  int send_idle = 25;
  int recv_idle = 69;

  int fault_count = 0;
  verdict_t verdicts_due[$];

  // ---------------------------------------------------------------
  // predictor state: weights, buffered sample, running sum, settings
  // ---------------------------------------------------------------
  logic signed [WEIGHT_W-1:0] w_store [FEATURES];
  logic signed [FEAT_W-1:0]   x_store [FEATURES];
  longint                     dot_sum;
  int                         taken;
  logic                       sum_clamped;
  logic [LR_W-1:0]            lr_q;
  logic signed [BIAS_W-1:0]   bias_q;

  // clamp to the accumulator range, raising the sticky flag on overflow
  function automatic longint clamp_acc(input longint v, inout logic flag);
    if (v > ACC_MAX) begin
      flag = 1'b1;
      return ACC_MAX;
    end
    if (v < ACC_MIN) begin
      flag = 1'b1;
      return ACC_MIN;
    end
    return v;
  endfunction

  // advance the perceptron by one accepted word; returns 1 when a verdict is due
  function automatic bit model_word(input req_word_t w, output verdict_t v);
    longint total;
    longint err;
    longint delta;
    longint nw;
    int i;
    v = '0;
    if (w.op == OP_LOAD) begin
      w_store[w.widx] = w.wval;
      return 1'b0;
    end
    if (w.op == OP_RESERVED) return 1'b0;

    // features beyond the ring are dropped, but last still closes the sample
    if (taken < FEATURES) begin
      x_store[taken] = w.feature;
      dot_sum = clamp_acc(dot_sum + longint'(w_store[taken]) * longint'(w.feature),
                          sum_clamped);
      taken++;
    end
    if (!w.last) return 1'b0;

    total = clamp_acc(dot_sum + (longint'(bias_q) <<< ACC_FRAC), sum_clamped);
    v.prediction = (total >= 0);
    v.saturated  = sum_clamped;

    // mode comes from the op of the closing word
    if (w.op == OP_TRAIN && w.label != v.prediction) begin
      err = w.label ? 2 : -2;
      for (i = 0; i < taken; i++) begin
        // round half up back to q16.16
        delta = (err * longint'(lr_q) * longint'(x_store[i]) + 2048) >>> 12;
        nw = longint'(w_store[i]) + delta;
        if (nw > W_MAX) begin
          nw = W_MAX;
          v.saturated = 1'b1;
        end
        if (nw < W_MIN) begin
          nw = W_MIN;
          v.saturated = 1'b1;
        end
        if (nw != longint'(w_store[i])) v.updated = 1'b1;
        w_store[i] = nw[WEIGHT_W-1:0];
      end
    end

    dot_sum     = 0;
    taken       = 0;
    sum_clamped = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------

  // features: some at the rails or zero, the rest anywhere in q4.12
  function automatic logic signed [FEAT_W-1:0] pick_feature();
    case ($urandom_range(15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  // weights: rails, full range, or modest values that keep sums in play
  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed(32'($urandom_range(0, 32'h1F_FFFF))) - 32'sh10_0000;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // every field random, so the don't-care bits toggle too
  function automatic req_word_t random_word();
    req_word_t w;
    w.op      = OP_W'($urandom);
    w.feature = pick_feature();
    w.label   = 1'($urandom);
    w.last    = 1'($urandom);
    w.widx    = IDX_W'($urandom);
    w.wval    = pick_weight();
    return w;
  endfunction

  // offer one word at a falling edge, hold it until taken, then log the verdict due
  task automatic send_word(input req_word_t w, input logic typed, input verdict_t typed_v);
    verdict_t v;
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= w.op;
    req_ch.feature      <= w.feature;
    req_ch.label        <= w.label;
    req_ch.last         <= w.last;
    req_ch.weight_index <= w.widx;
    req_ch.weight_value <= w.wval;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (model_word(w, v)) verdicts_due.push_back(typed ? typed_v : v);
    @(negedge clk);
  endtask

  // register write at a falling edge; the caller drops cfg_write afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_LRATE) lr_q = data[LR_W-1:0];
    else bias_q = data[BIAS_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_rate_and_bias(input logic [LR_W-1:0] lr, input logic [BIAS_W-1:0] b);
    write_reg(REG_LRATE, lr);
    write_reg(REG_BIAS, {{(CFG_W-BIAS_W){b[BIAS_W-1]}}, b});
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // let every verdict come home, then give the block time to go quiet
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly whole samples with random content; some loads, reserved ops
  // and over-long samples mixed in
  task automatic run_random(input int target);
    req_word_t w;
    int count;
    int roll;
    int len;
    int k;
    logic train;
    count = 0;
    while (count < target) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        w = random_word();
        w.op = OP_LOAD;
        send_word(w, 1'b0, '0);
        count++;
      end else if (roll < 15) begin
        // ignored by the block, not counted
        w = random_word();
        w.op = OP_RESERVED;
        send_word(w, 1'b0, '0);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(FEATURES + 1, FEATURES + 4)
                                       : $urandom_range(1, FEATURES);
        train = 1'($urandom);
        for (k = 0; k < len; k++) begin
          // weight load landing inside a sample
          if ($urandom_range(19) == 0) begin
            w = random_word();
            w.op = OP_LOAD;
            send_word(w, 1'b0, '0);
            count++;
          end
          w = random_word();
          w.last = (k == len - 1);
          if (w.last) w.op = train ? OP_TRAIN : OP_PREDICT;
          else w.op = $urandom_range(1) ? OP_TRAIN : OP_PREDICT;
          send_word(w, 1'b0, '0);
          count++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------
  // opening rows, run at reset settings (rate 655, bias 0)
  // ---------------------------------------------------------------
  localparam int OPENING_ROWS = 18;
  localparam verdict_t NONE = '0;

  opening_row_t opening_rows [OPENING_ROWS] = '{
    // fresh weights are zero: sum zero predicts +1
    '{'{OP_PREDICT, 16'sh7FFF, 1'b0, 1'b1, 4'd5, 32'sh0F0F_0F0F}, 1'b1, '{1'b1, 1'b0, 1'b0}},
    // wrong guess on the negative rail: weight 0 moves by 10480
    '{'{OP_TRAIN, 16'sh8000, 1'b0, 1'b1, 4'd10, 32'shF0F0_F0F0}, 1'b1, '{1'b1, 1'b1, 1'b0}},
    // reserved op leaves everything alone
    '{'{OP_RESERVED, 16'sh5A5A, 1'b1, 1'b1, 4'd9, 32'sh1234_5678}, 1'b0, NONE},
    '{'{OP_LOAD, 16'sh0000, 1'b0, 1'b0, 4'd0, 32'sh8000_0000}, 1'b0, NONE},
    '{'{OP_LOAD, 16'shFFFF, 1'b1, 1'b1, 4'd1, 32'sh8000_0000}, 1'b0, NONE},
    // two max products overflow the sum: clamped, flagged, +1
    '{'{OP_PREDICT, 16'sh8000, 1'b1, 1'b0, 4'd0, 32'sh0000_0000}, 1'b0, NONE},
    '{'{OP_PREDICT, 16'sh8000, 1'b0, 1'b1, 4'd15, 32'shFFFF_FFFF}, 1'b1, '{1'b1, 1'b0, 1'b1}},
    '{'{OP_LOAD, 16'sh1234, 1'b0, 1'b0, 4'd1, 32'sh7FFF_FFFF}, 1'b0, NONE},
    // opened as predict, closed as train; weight 1 runs into the rail
    '{'{OP_PREDICT, 16'sh7FFF, 1'b1, 1'b0, 4'd3, 32'sh0000_0001}, 1'b0, NONE},
    '{'{OP_TRAIN, 16'sh7FFF, 1'b1, 1'b1, 4'd12, 32'sh7654_3210}, 1'b0, NONE},
    '{'{OP_LOAD, 16'sh0000, 1'b0, 1'b0, 4'd15, 32'sh7FFF_FFFF}, 1'b0, NONE},
    // load between features of one sample, closed as predict
    '{'{OP_TRAIN, 16'sh1000, 1'b0, 1'b0, 4'd6, 32'sh0000_0000}, 1'b0, NONE},
    '{'{OP_LOAD, 16'sh7FFF, 1'b1, 1'b1, 4'd1, 32'sh0000_0000}, 1'b0, NONE},
    '{'{OP_PREDICT, 16'sh1000, 1'b1, 1'b1, 4'd2, 32'shAAAA_5555}, 1'b0, NONE},
    // zero feature gives sum zero, label +1 is right: nothing moves
    '{'{OP_TRAIN, 16'sh0000, 1'b1, 1'b1, 4'd4, 32'sh5555_AAAA}, 1'b1, '{1'b1, 1'b0, 1'b0}},
    '{'{OP_TRAIN, 16'sh7FFF, 1'b0, 1'b0, 4'd8, 32'sh0000_0000}, 1'b0, NONE},
    '{'{OP_TRAIN, 16'sh8000, 1'b0, 1'b1, 4'd7, 32'sh0000_0000}, 1'b0, NONE},
    // smallest negative feature, rounding of a tiny step
    '{'{OP_TRAIN, 16'shFFFF, 1'b1, 1'b1, 4'd11, 32'sh0000_0000}, 1'b0, NONE}
  };

  // ---------------------------------------------------------------
  // response side: random back-pressure, in-order checking
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.prediction, rsp_ch.updated, rsp_ch.saturated};
      if (verdicts_due.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected verdict word: pred %b upd %b sat %b",
                   got.prediction, got.updated, got.saturated);
        fault_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.prediction !== want.prediction || got.updated !== want.updated ||
            got.saturated !== want.saturated) begin
          if (fault_count < 10)
            $display("verdict mismatch: want pred %b upd %b sat %b, got pred %b upd %b sat %b",
                     want.prediction, want.updated, want.saturated,
                     got.prediction, got.updated, got.saturated);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    int r;
    // every input known from time zero
    cfg_write           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_PREDICT;
    req_ch.feature      = '0;
    req_ch.label        = 1'b0;
    req_ch.last         = 1'b0;
    req_ch.weight_index = '0;
    req_ch.weight_value = '0;
    rsp_ch.ready        = 1'b0;

    // predictor at its reset values
    for (r = 0; r < FEATURES; r++) begin
      w_store[r] = '0;
      x_store[r] = '0;
    end
    dot_sum     = 0;
    taken       = 0;
    sum_clamped = 1'b0;
    lr_q        = LR_RESET;
    bias_q      = BIAS_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles a quarter of the time, receiver most of it
    for (r = 0; r < OPENING_ROWS; r++)
      send_word(opening_rows[r].w, opening_rows[r].typed, opening_rows[r].v);
    drain();
    set_rate_and_bias(16'hFFFF, 8'sh80);
    run_random(430);

    // swap the idle odds, other extremes of both registers
    drain();
    send_idle = 69;
    recv_idle = 25;
    set_rate_and_bias(16'h0000, 8'sh7F);
    run_random(430);

    // full speed both ways, random settings
    drain();
    send_idle = 0;
    recv_idle = 0;
    set_rate_and_bias(LR_W'($urandom), BIAS_W'($urandom));
    run_random(440);
    drain();

    if (fault_count == 0 && verdicts_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard, far past the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
